// File: design/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int AtanEntries = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [25:0] TurnScale = 26'd44798134;
  localparam logic [15:0] RadiusReset = 16'd2163;
  localparam logic [15:0] InvSpacingReset = 16'd862;
  // ceil(2^55 / 15625): floor(n / 15625) = (n * DistRecip) >> 55 for n < 2^42
  localparam logic [41:0] DistRecip = 42'd2305843009214;

  localparam logic CfgRadius = 1'b0;
  localparam logic CfgInvSpacing = 1'b1;

  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 34'sh20000000;
      5'd1: atan_lut = 34'sh12E4051E;
      5'd2: atan_lut = 34'sh09FB385B;
      5'd3: atan_lut = 34'sh051111D4;
      5'd4: atan_lut = 34'sh028B0D43;
      5'd5: atan_lut = 34'sh0145D7E1;
      5'd6: atan_lut = 34'sh00A2F61E;
      5'd7: atan_lut = 34'sh00517C55;
      5'd8: atan_lut = 34'sh0028BE53;
      5'd9: atan_lut = 34'sh00145F2F;
      5'd10: atan_lut = 34'sh000A2F98;
      5'd11: atan_lut = 34'sh000517CC;
      5'd12: atan_lut = 34'sh00028BE6;
      5'd13: atan_lut = 34'sh000145F3;
      5'd14: atan_lut = 34'sh0000A2FA;
      5'd15: atan_lut = 34'sh0000517D;
      5'd16: atan_lut = 34'sh000028BE;
      5'd17: atan_lut = 34'sh0000145F;
      5'd18: atan_lut = 34'sh00000A30;
      5'd19: atan_lut = 34'sh00000518;
      5'd20: atan_lut = 34'sh0000028C;
      5'd21: atan_lut = 34'sh00000146;
      5'd22: atan_lut = 34'sh000000A3;
      5'd23: atan_lut = 34'sh00000051;
      default: atan_lut = 34'sh0;
    endcase
  endfunction

endpackage

// File: design/ddo_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// done stays high from the last micro-rotation until the next start.
module ddo_cordic import ddo_pkg::*; #(
  parameter int Steps = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);

  localparam int N = (Steps > AtanEntries) ? AtanEntries : Steps;

  logic signed [33:0] x, y, z;
  logic [4:0] idx;
  logic busy, flip;
  logic [15:0] r;
  logic signed [33:0] xs, ys;

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign r = (16'(angle + 16'h4000) >= 16'h8000) ? 16'(angle + 16'h8000) : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        idx <= '0;
        flip <= (16'(angle + 16'h4000) >= 16'h8000);
        x <= CordicGain;
        y <= '0;
        z <= {{2{r[15]}}, r, 16'h0};
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_lut(idx);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_lut(idx);
        end
        idx <= idx + 5'd1;
        if (idx == 5'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_q30 = flip ? -x : x;
  assign sin_q30 = flip ? -y : y;

endmodule

// File: design/ddo_mul.sv
`timescale 1ns / 1ps
// Shared registered signed multiplier, 34 x 34.
module ddo_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: design/diff_drive_odometry.sv
`timescale 1ns / 1ps
// Differential-drive odometry, one Euler pose step per input transfer.
// One item in flight: the next input can be taken in the cycle after the result
// transfer at the earliest.
// Synchronous reset clears pose to zero and the config registers to their defaults.
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] left_speed,
  input  logic signed [15:0] right_speed,
  input  logic [15:0] step_time_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [15:0] heading
);

  // M1..M12 run the shared multiplier while the CORDIC works on the old heading.
  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10, S_M11,
    S_M12, S_WAIT, S_DX, S_DY, S_OUT
  } state_t;

  state_t state;
  logic [15:0] wheel_radius, inv_wheel_spacing, dt;
  logic signed [16:0] sum, diff;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0] angle;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic signed [33:0] travel, w;
  logic signed [49:0] num, wd;
  logic [48:0] mag, num_rnd;
  logic [41:0] nd;
  logic [83:0] qacc;
  logic [49:0] wfull;
  logic [63:0] tacc, tsum;
  logic signed [33:0] cs, sn;
  logic cdone;
  logic signed [67:0] rnd;
  logic signed [32:0] px, py;

  // Single multiplier shared by every product step.
  ddo_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  ddo_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(state == S_IDLE && in_valid),
    .angle(angle), .done(cdone), .cos_q30(cs), .sin_q30(sn)
  );

  assign cfg_ready = !rst;
  assign in_stall = rst || (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign pose_x = pos_x;
  assign pose_y = pos_y;
  assign heading = angle;

  // Operands go in one state; the registered product is read in the next.
  // M5..M8: 21-bit partial products of nd * DistRecip.
  // M10, M11: w*dt split at bit 25, each half times the turn scale.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_M1: begin ma = 34'(sum); mb = 34'(wheel_radius); end
      S_M2: begin ma = mp[33:0]; mb = 34'(dt); end
      S_M3: begin ma = 34'(diff); mb = 34'(wheel_radius); end
      S_M4: begin ma = mp[33:0]; mb = 34'(inv_wheel_spacing); end
      S_M5: begin ma = 34'(nd[20:0]); mb = 34'(DistRecip[20:0]); end
      S_M6: begin ma = 34'(nd[20:0]); mb = 34'(DistRecip[41:21]); end
      S_M7: begin ma = 34'(nd[41:21]); mb = 34'(DistRecip[20:0]); end
      S_M8: begin ma = 34'(nd[41:21]); mb = 34'(DistRecip[41:21]); end
      S_M9: begin ma = w; mb = 34'(dt); end
      S_M10: begin ma = 34'(mp[24:0]); mb = 34'(TurnScale); end
      S_M11: begin ma = 34'($signed(wd[49:25])); mb = 34'(TurnScale); end
      S_WAIT: begin ma = travel; mb = cs; end
      S_DX: begin ma = travel; mb = sn; end
      default: ;
    endcase
  end

  // Division by 2e6, round half away: add 1e6 to |num|, drop 7 bits, then
  // multiply by the reciprocal of 15625 and keep bits 83..55 (exact here).
  assign mag = num[49] ? 49'(-num) : 49'(num);
  assign num_rnd = mag + 49'd1000000;
  assign nd = num_rnd[48:7];
  // Turn rate, rounded to 2^-16 rad/s.
  assign wfull = mp[49:0] + 50'd32768;
  // Heading step, modulo 2^64; high half of the split product lands at bit 25.
  assign tsum = tacc + (mp[63:0] << 25) + 64'h0000_8000_0000_0000;
  assign rnd = mp + 68'sd137438953472;
  assign px = 33'(pos_x) + 33'(rnd >>> 38);
  assign py = 33'(pos_y) + 33'(rnd >>> 38);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel_radius <= RadiusReset;
      inv_wheel_spacing <= InvSpacingReset;
      pos_x <= '0;
      pos_y <= '0;
      angle <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgRadius: wheel_radius <= cfg_data;
          CfgInvSpacing: inv_wheel_spacing <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          sum <= 17'(left_speed) + 17'(right_speed);
          diff <= 17'(right_speed) - 17'(left_speed);
          dt <= step_time_us;
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: begin num <= mp[49:0]; state <= S_M4; end
        S_M4: state <= S_M5;
        S_M5: begin w <= wfull[49:16]; state <= S_M6; end
        S_M6: begin qacc <= 84'(mp[41:0]); state <= S_M7; end
        S_M7: begin qacc <= qacc + (84'(mp[41:0]) << 21); state <= S_M8; end
        S_M8: begin qacc <= qacc + (84'(mp[41:0]) << 21); state <= S_M9; end
        S_M9: begin qacc <= qacc + (84'(mp[41:0]) << 42); state <= S_M10; end
        S_M10: begin
          wd <= mp[49:0];
          travel <= num[49] ? -34'(qacc[83:55]) : 34'(qacc[83:55]);
          state <= S_M11;
        end
        S_M11: begin tacc <= 64'(mp[50:0]); state <= S_M12; end
        S_M12: begin angle <= angle + tsum[63:48]; state <= S_WAIT; end
        S_WAIT: if (cdone) state <= S_DX;
        S_DX: begin
          pos_x <= (px > 33'sd2147483647) ? 32'sh7FFFFFFF :
                   (px < -33'sd2147483648) ? 32'sh80000000 : px[31:0];
          state <= S_DY;
        end
        S_DY: begin
          pos_y <= (py > 33'sd2147483647) ? 32'sh7FFFFFFF :
                   (py < -33'sd2147483648) ? 32'sh80000000 : py[31:0];
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
